FILE: sv/acsmm_pkg.sv
// Shared types and constants for the converter channel scan tracker.
// No dependencies; imported by acsmm_value_bank and the top level.
`timescale 1ns / 1ps

package acsmm_pkg;

    // Request codes carried by req_type
    localparam logic [1:0] REQ_CONV  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_OSC_CAL = 3'd0;
    localparam logic [2:0] CFG_MUX_CH0 = 3'd1;
    localparam logic [2:0] CFG_MUX_CH1 = 3'd2;
    localparam logic [2:0] CFG_MUX_CH2 = 3'd3;
    localparam logic [2:0] CFG_MUX_CH3 = 3'd4;

    // Reset values of the configuration registers
    localparam logic [7:0] OSC_CAL_RST = 8'h00;
    localparam logic [7:0] MUX_CH0_RST = 8'b1000_1111;
    localparam logic [7:0] MUX_CH1_RST = 8'b1000_0001;
    localparam logic [7:0] MUX_CH2_RST = 8'b1001_0001;
    localparam logic [7:0] MUX_CH3_RST = 8'b0000_0001;

    // Channels that own a mux register
    localparam int MUX_REGS = 4;

    // Host byte map
    localparam logic [6:0] ADDR_OSC_CAL = 7'd1;
    localparam logic [6:0] MAP_FIRST    = 7'd2;

    // Value word reset patterns
    localparam logic [15:0] WORD_ZERO = 16'h0000;
    localparam logic [15:0] WORD_ONES = 16'hFFFF;

    // One input item
    typedef struct packed {
        logic [1:0] req;
        logic [9:0] sample;
        logic [6:0] address;
        logic [7:0] write_data;
        logic       busy;
    } acsmm_item_t;

    // Per-item status from the value bank
    typedef struct packed {
        logic       start;
        logic [7:0] rdata;
        logic       hit;
    } acsmm_status_t;

endpackage

FILE: sv/acsmm_value_bank.sv
// Per-channel current/min/max words, channel pointer and discard flag.
// Applies one item per step; depends on acsmm_pkg.
`timescale 1ns / 1ps

module acsmm_value_bank #(
    parameter int CHANNELS = 4,
    parameter int CH_W     = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  acsmm_pkg::acsmm_item_t item,
    output acsmm_pkg::acsmm_status_t status,
    output logic [CH_W-1:0]        chan_next
);
    import acsmm_pkg::*;

    localparam logic [7:0] MAP_END = 8'(2 + 6 * CHANNELS);
    localparam logic [5:0] CH6     = 6'(CHANNELS);
    localparam logic [CH_W:0] CH_LAST = (CH_W + 1)'(CHANNELS - 1);

    logic [15:0]     cur_reg [CHANNELS];
    logic [15:0]     min_reg [CHANNELS];
    logic [15:0]     max_reg [CHANNELS];
    logic [CH_W-1:0] chan_reg;
    logic            keep_reg;
    logic            keep_next;

    logic            in_map;
    logic [6:0]      offset;
    logic [5:0]      word_idx;
    logic [5:0]      host_ch6;
    logic [1:0]      host_arr;
    logic [CH_W-1:0] sel;
    logic [15:0]     cur_rd, min_rd, max_rd, host_rd;
    logic [15:0]     smp16, wmerge;
    logic            cur_we, min_we, max_we;
    logic [15:0]     cur_wd, min_wd, max_wd;

    // Host address decode: word, array (current/min/max) and channel
    assign in_map   = ({1'b0, item.address} >= {1'b0, MAP_FIRST}) &&
                      ({1'b0, item.address} < MAP_END);
    assign offset   = item.address - MAP_FIRST;
    assign word_idx = offset[6:1];

    always_comb
    begin
        if (word_idx < CH6)
        begin
            host_arr = 2'd0;
            host_ch6 = word_idx;
        end
        else if (word_idx < 6'(2 * CHANNELS))
        begin
            host_arr = 2'd1;
            host_ch6 = word_idx - CH6;
        end
        else
        begin
            host_arr = 2'd2;
            host_ch6 = word_idx - 6'(2 * CHANNELS);
        end
    end

    // One entry address per item: the scan channel or the host word
    assign sel    = (item.req == REQ_CONV) ? chan_reg : host_ch6[CH_W-1:0];
    assign cur_rd = cur_reg[sel];
    assign min_rd = min_reg[sel];
    assign max_rd = max_reg[sel];
    assign smp16  = {6'd0, item.sample};

    always_comb
    begin
        unique case (host_arr)
            2'd0:    host_rd = cur_rd;
            2'd1:    host_rd = min_rd;
            default: host_rd = max_rd;
        endcase
    end

    assign wmerge = offset[0] ? {item.write_data, host_rd[7:0]}
                              : {host_rd[15:8], item.write_data};

    // Item decode: word updates, channel advance, read byte
    always_comb
    begin
        cur_we       = 1'b0;
        min_we       = 1'b0;
        max_we       = 1'b0;
        cur_wd       = smp16;
        min_wd       = smp16;
        max_wd       = smp16;
        keep_next    = keep_reg;
        chan_next    = chan_reg;
        status.start = 1'b0;
        status.rdata = 8'd0;
        status.hit   = 1'b0;
        unique case (item.req)
            REQ_CONV:
            begin
                if (!keep_reg)
                begin
                    status.start = 1'b1;
                    keep_next    = 1'b1;
                end
                else
                begin
                    if (!item.busy)
                    begin
                        cur_we = 1'b1;
                        min_we = (min_rd > smp16);
                        max_we = (max_rd < smp16);
                    end
                    // stored value matches when just written, else compare
                    if (!item.busy || (cur_rd == smp16))
                    begin
                        chan_next    = ({1'b0, chan_reg} == CH_LAST) ? '0
                                       : chan_reg + 1'b1;
                        status.start = 1'b1;
                        keep_next    = 1'b0;
                    end
                end
            end
            REQ_READ:
            begin
                if (in_map)
                begin
                    status.rdata = offset[0] ? host_rd[15:8] : host_rd[7:0];
                    status.hit   = 1'b1;
                end
            end
            REQ_WRITE:
            begin
                if (in_map)
                begin
                    cur_we = (host_arr == 2'd0);
                    min_we = (host_arr == 2'd1);
                    max_we = (host_arr == 2'd2);
                    cur_wd = wmerge;
                    min_wd = wmerge;
                    max_wd = wmerge;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Value words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                cur_reg[i] <= WORD_ZERO;
                min_reg[i] <= WORD_ONES;
                max_reg[i] <= WORD_ZERO;
            end
        end
        else if (step)
        begin
            if (cur_we)
                cur_reg[sel] <= cur_wd;
            if (min_we)
                min_reg[sel] <= min_wd;
            if (max_we)
                max_reg[sel] <= max_wd;
        end
    end

    // Scan pointer and discard flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= '0;
            keep_reg <= 1'b0;
        end
        else if (step)
        begin
            chan_reg <= chan_next;
            keep_reg <= keep_next;
        end
    end

    // Checks
    a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, chan_reg} <= CH_LAST)
        else $error("scan channel out of range");

    a_kept_free_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.req == REQ_CONV && keep_reg && !item.busy) |=> !keep_reg)
        else $error("kept sample without transfer did not advance");

    a_discard_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (item.req == REQ_CONV && !keep_reg) |-> status.start)
        else $error("discarded result did not restart conversion");

endmodule

FILE: sv/adc_channel_scan_min_max_tracker_core.sv
// Top level of the converter channel scan tracker: input stage, config
// registers, result register. Depends on acsmm_pkg and acsmm_value_bank.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_stall) carries one event per transfer:
//   conversion done, host byte read or host byte write. Output channel
//   (out_valid/out_stall) returns exactly one result per event: the
//   start flag, the mux word of the selected channel, and the read byte
//   with its hit flag.
//   Path: an event passes the input register, then the result register,
//   before out_valid rises; a stalled receiver holds it there.
//   Throughput: one event per cycle while the receiver does not stall;
//   the value bank updates all state of an event together as it moves on.
//   When the receiver stalls, the result register holds; one more event
//   waits in the input register, after which in_stall rises.
//   Configuration (wr_en/wr_index/wr_data) writes osc_cal or one of the
//   four mux words per write; write it only while the block is empty.
//   Reset: current and maximum words clear, minimum words go to all
//   ones, scan restarts at channel zero with its first result discarded,
//   config registers return to their defaults. No clearing pass.
module adc_channel_scan_min_max_tracker_core #(
    parameter int CHANNELS = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] req_type,
    input  logic [9:0] sample,
    input  logic [6:0] address,
    input  logic [7:0] write_data,
    input  logic       transfer_active,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       start_conversion,
    output logic [7:0] mux_word,
    output logic [7:0] read_data,
    output logic       read_hit,
    input  logic       wr_en,
    input  logic [2:0] wr_index,
    input  logic [7:0] wr_data
);
    import acsmm_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic            in_v_reg;
    acsmm_item_t     item_reg;
    logic            out_v_reg;
    logic            adv;
    logic            in_fire;
    acsmm_status_t   status;
    logic [CH_W-1:0] chan_next;
    logic [3:0]      chan_ext;
    logic [7:0]      mux_next;
    logic [7:0]      rdata_next;
    logic            hit_next;
    logic            osc_hit;

    logic [7:0] osc_cal_reg;
    logic [7:0] mux_reg [MUX_REGS];

    logic       start_reg;
    logic [7:0] mux_word_reg;
    logic [7:0] read_data_reg;
    logic       read_hit_reg;

    // Handshake: item moves on when the result slot is free or draining
    assign adv      = in_v_reg && (!out_v_reg || !out_stall);
    assign in_stall = in_v_reg && !adv;
    assign in_fire  = in_valid && !in_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (in_fire)
            in_v_reg <= 1'b1;
        else if (adv)
            in_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.req        <= req_type;
            item_reg.sample     <= sample;
            item_reg.address    <= address;
            item_reg.write_data <= write_data;
            item_reg.busy       <= transfer_active;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            osc_cal_reg <= OSC_CAL_RST;
            mux_reg[0]  <= MUX_CH0_RST;
            mux_reg[1]  <= MUX_CH1_RST;
            mux_reg[2]  <= MUX_CH2_RST;
            mux_reg[3]  <= MUX_CH3_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_OSC_CAL: osc_cal_reg <= wr_data;
                CFG_MUX_CH0: mux_reg[0]  <= wr_data;
                CFG_MUX_CH1: mux_reg[1]  <= wr_data;
                CFG_MUX_CH2: mux_reg[2]  <= wr_data;
                CFG_MUX_CH3: mux_reg[3]  <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    // Value bank
    acsmm_value_bank #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W)
    ) u_bank (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (adv),
        .item      (item_reg),
        .status    (status),
        .chan_next (chan_next)
    );

    // Mux word of the channel after the step; channels past four get zero
    assign chan_ext = 4'(chan_next);
    assign mux_next = (chan_ext < 4'(MUX_REGS)) ? mux_reg[chan_ext[1:0]] : 8'd0;

    // Calibration byte at address one, value map from the bank
    assign osc_hit    = (item_reg.req == REQ_READ) && (item_reg.address == ADDR_OSC_CAL);
    assign rdata_next = osc_hit ? osc_cal_reg : status.rdata;
    assign hit_next   = osc_hit || status.hit;

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (adv)
            out_v_reg <= 1'b1;
        else if (!out_stall)
            out_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            start_reg     <= status.start;
            mux_word_reg  <= mux_next;
            read_data_reg <= rdata_next;
            read_hit_reg  <= hit_next;
        end
    end

    assign out_valid        = out_v_reg;
    assign start_conversion = start_reg;
    assign mux_word         = mux_word_reg;
    assign read_data        = read_data_reg;
    assign read_hit         = read_hit_reg;

    // Checks
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_v_reg && out_v_reg && out_stall))
        else $error("input stalled while the pipeline can move");

    a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid)
        else $error("advanced item produced no result");

    a_miss_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !read_hit) |-> (read_data == 8'd0))
        else $error("nonzero read byte without a hit");

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for adc_channel_scan_min_max_tracker_core.
// Depends on acsmm_pkg; predicts every result and checks it against the DUT.
`timescale 1ns / 1ps

module tb_top;
    import acsmm_pkg::*;

    localparam int CH = 4;
    localparam int MAP_END = MAP_FIRST + 6 * CH;
    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int HOLD_OFF_CYCLES = 40;

    typedef struct packed {
        logic       start;
        logic [7:0] mux;
        logic [7:0] rdata;
        logic       hit;
    } scan_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b1;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] req_type = REQ_NONE;
    logic [9:0] sample = '0;
    logic [6:0] address = '0;
    logic [7:0] write_data = '0;
    logic       transfer_active = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       start_conversion;
    logic [7:0] mux_word;
    logic [7:0] read_data;
    logic       read_hit;
    logic       wr_en = 1'b0;
    logic [2:0] wr_index = CFG_OSC_CAL;
    logic [7:0] wr_data = '0;

    // Predictor state
    logic [15:0] cur_word [CH];
    logic [15:0] min_word [CH];
    logic [15:0] max_word [CH];
    int unsigned chan_sel;
    bit          keep_next;
    logic [7:0]  cal_byte;
    logic [7:0]  mux_cfg [MUX_REGS];

    scan_result_t scan_results_q[$];
    int           mismatch_count = 0;
    int           idle_cycles = 0;
    bit           tx_idle_en = 1'b1;
    bit           rx_idle_en = 1'b1;
    int           rx_hold_cycles = 0;

    adc_channel_scan_min_max_tracker_core #(
        .CHANNELS(CH)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .req_type         (req_type),
        .sample           (sample),
        .address          (address),
        .write_data       (write_data),
        .transfer_active  (transfer_active),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .start_conversion (start_conversion),
        .mux_word         (mux_word),
        .read_data        (read_data),
        .read_hit         (read_hit),
        .wr_en            (wr_en),
        .wr_index         (wr_index),
        .wr_data          (wr_data)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    task automatic reset_tracker_model();
        for (int i = 0; i < CH; i++)
        begin
            cur_word[i] = WORD_ZERO;
            min_word[i] = WORD_ONES;
            max_word[i] = WORD_ZERO;
        end
        chan_sel   = 0;
        keep_next  = 1'b0;
        cal_byte   = OSC_CAL_RST;
        mux_cfg[0] = MUX_CH0_RST;
        mux_cfg[1] = MUX_CH1_RST;
        mux_cfg[2] = MUX_CH2_RST;
        mux_cfg[3] = MUX_CH3_RST;
    endtask

    // Value word of a bank and channel: bank 0 current, 1 min, else max.
    function automatic logic [15:0] value_word(int unsigned bank, int unsigned ch);
        case (bank)
            0: return cur_word[ch];
            1: return min_word[ch];
            default: return max_word[ch];
        endcase
    endfunction

    function automatic scan_result_t predict_scan_event(acsmm_item_t ev);
        scan_result_t res;
        int unsigned  off;
        int unsigned  bank;
        int unsigned  ch;
        logic [15:0]  word;
        logic [15:0]  smp;
        bit           in_map;
        res    = '0;
        smp    = {6'd0, ev.sample};
        in_map = (ev.address >= MAP_FIRST) && (int'(ev.address) < MAP_END);
        off    = in_map ? int'(ev.address) - int'(MAP_FIRST) : 0;
        bank   = (off >> 1) / CH;
        ch     = (off >> 1) % CH;
        if (chan_sel >= CH)
            chan_sel = 0;
        case (ev.req)
            REQ_CONV:
            begin
                // first result after a channel switch is thrown away
                if (!keep_next)
                begin
                    res.start = 1'b1;
                    keep_next = 1'b1;
                end
                else
                begin
                    if (!ev.busy)
                    begin
                        cur_word[chan_sel] = smp;
                        if (min_word[chan_sel] > smp)
                            min_word[chan_sel] = smp;
                        if (max_word[chan_sel] < smp)
                            max_word[chan_sel] = smp;
                    end
                    // advance only once the stored value matches the sample
                    if (cur_word[chan_sel] == smp)
                    begin
                        chan_sel  = (chan_sel + 1) % CH;
                        res.start = 1'b1;
                        keep_next = 1'b0;
                    end
                end
            end
            REQ_READ:
            begin
                if (ev.address == ADDR_OSC_CAL)
                begin
                    res.rdata = cal_byte;
                    res.hit   = 1'b1;
                end
                else if (in_map)
                begin
                    word      = value_word(bank, ch);
                    res.rdata = off[0] ? word[15:8] : word[7:0];
                    res.hit   = 1'b1;
                end
            end
            REQ_WRITE:
            begin
                // host writes land regardless of the transfer flag
                if (in_map)
                begin
                    word = value_word(bank, ch);
                    if (off[0])
                        word[15:8] = ev.write_data;
                    else
                        word[7:0] = ev.write_data;
                    case (bank)
                        0: cur_word[ch] = word;
                        1: min_word[ch] = word;
                        default: max_word[ch] = word;
                    endcase
                end
            end
            default: ;
        endcase
        res.mux = (chan_sel < MUX_REGS) ? mux_cfg[chan_sel] : 8'd0;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Result checker and watchdog
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        scan_result_t exp_res;
        scan_result_t got_res;
        if (out_valid && !out_stall)
        begin
            got_res = '{start_conversion, mux_word, read_data, read_hit};
            if (scan_results_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: start=%0d mux=%02h rdata=%02h hit=%0d",
                             got_res.start, got_res.mux, got_res.rdata, got_res.hit);
            end
            else
            begin
                exp_res = scan_results_q.pop_front();
                if (got_res.start !== exp_res.start || got_res.mux !== exp_res.mux ||
                    got_res.rdata !== exp_res.rdata || got_res.hit !== exp_res.hit)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp start=%0d mux=%02h rdata=%02h hit=%0d",
                                 exp_res.start, exp_res.mux, exp_res.rdata, exp_res.hit,
                                 " got start=%0d mux=%02h rdata=%02h hit=%0d",
                                 got_res.start, got_res.mux, got_res.rdata, got_res.hit);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random stall per result, plus an occasional long hold-off
    // ---------------------------------------------------------------
    initial
    begin
        int gap;
        @(negedge clk);
        forever
        begin
            gap = rx_idle_en ? $urandom_range(0, 3) : 0;
            if (rx_hold_cycles > 0)
            begin
                gap = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    // ---------------------------------------------------------------
    // Sender side; every task here is entered at a falling edge
    // ---------------------------------------------------------------
    task automatic send_item(acsmm_item_t ev);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid        <= 1'b1;
        req_type        <= ev.req;
        sample          <= ev.sample;
        address         <= ev.address;
        write_data      <= ev.write_data;
        transfer_active <= ev.busy;
        do
            @(posedge clk);
        while (in_stall);
        scan_results_q.push_back(predict_scan_event(ev));
        @(negedge clk);
    endtask

    // Stop offering, then wait for every outstanding result to come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (scan_results_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write all five registers back to back; block must be empty.
    task automatic program_regs(logic [7:0] vals [5]);
        for (int i = 0; i < 5; i++)
        begin
            wr_en    <= 1'b1;
            wr_index <= i[2:0];
            wr_data  <= vals[i];
            if (i == int'(CFG_OSC_CAL))
                cal_byte = vals[i];
            else
                mux_cfg[i - int'(CFG_MUX_CH0)] = vals[i];
            @(negedge clk);
        end
        wr_en <= 1'b0;
        @(negedge clk);
    endtask

    function automatic acsmm_item_t mk(logic [1:0] req, logic [9:0] smp, logic [6:0] addr,
                                       logic [7:0] data, logic busy);
        return '{req, smp, addr, data, busy};
    endfunction

    // Mostly conversions so the scan keeps moving, with host traffic mixed in.
    function automatic acsmm_item_t rand_scan_event();
        acsmm_item_t ev;
        int          pick;
        ev.req        = REQ_NONE;
        ev.sample     = 10'($urandom_range(0, 1023));
        ev.address    = 7'(($urandom_range(0, 4) != 0) ? $urandom_range(0, MAP_END + 1)
                                                       : $urandom_range(0, 127));
        ev.write_data = 8'($urandom_range(0, 255));
        ev.busy       = ($urandom_range(0, 3) == 0);
        pick          = $urandom_range(0, 99);
        if (pick < 55)
        begin
            ev.req = REQ_CONV;
            case ($urandom_range(0, 9))
                0: ev.sample = '0;
                1: ev.sample = '1;
                2, 3: ev.sample = cur_word[chan_sel % CH][9:0];
                default: ;
            endcase
        end
        else if (pick < 75)
            ev.req = REQ_READ;
        else if (pick < 95)
            ev.req = REQ_WRITE;
        return ev;
    endfunction

    task automatic run_random_events(int count);
        for (int i = 0; i < count; i++)
        begin
            // switch at random between idle-free stretches and random gaps
            if (i % 64 == 0)
            begin
                tx_idle_en = ($urandom_range(0, 2) != 0);
                rx_idle_en = ($urandom_range(0, 2) != 0);
            end
            send_item(rand_scan_event());
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed_events();
        // reset contents, unmapped reads and the unused request type
        send_item(mk(REQ_READ,  10'd0,   7'd0,   8'h00, 1'b0));
        send_item(mk(REQ_READ,  10'd0,   7'd1,   8'h00, 1'b0));
        send_item(mk(REQ_READ,  10'd0,   7'd2,   8'h00, 1'b0));
        send_item(mk(REQ_READ,  10'd0,   7'd10,  8'h00, 1'b0));
        send_item(mk(REQ_READ,  10'd0,   7'd25,  8'h00, 1'b0));
        send_item(mk(REQ_READ,  10'd0,   7'd26,  8'h00, 1'b0));
        send_item(mk(REQ_READ,  10'd0,   7'd127, 8'h00, 1'b0));
        send_item(mk(REQ_NONE,  10'd1023, 7'd127, 8'hFF, 1'b1));
        // discard, then keep sample 0 on channel 0
        send_item(mk(REQ_CONV,  10'd5,   7'd0,   8'h00, 1'b0));
        send_item(mk(REQ_CONV,  10'd0,   7'd0,   8'h00, 1'b0));
        // discard, then keep full scale on channel 1
        send_item(mk(REQ_CONV,  10'd1023, 7'd0,  8'h00, 1'b0));
        send_item(mk(REQ_CONV,  10'd1023, 7'd0,  8'h00, 1'b0));
        // channel 2 frozen by a host transfer: value differs, scan waits
        send_item(mk(REQ_CONV,  10'd7,   7'd0,   8'h00, 1'b1));
        send_item(mk(REQ_CONV,  10'd7,   7'd0,   8'h00, 1'b1));
        // host write during a transfer makes the value match, scan advances
        send_item(mk(REQ_WRITE, 10'd0,   7'd6,   8'h07, 1'b1));
        send_item(mk(REQ_WRITE, 10'd0,   7'd7,   8'h00, 1'b1));
        send_item(mk(REQ_CONV,  10'd7,   7'd0,   8'h00, 1'b1));
        // writes outside the map are dropped, one inside it lands and is read back
        send_item(mk(REQ_WRITE, 10'd0,   7'd0,   8'hFF, 1'b0));
        send_item(mk(REQ_WRITE, 10'd0,   7'd1,   8'hFF, 1'b0));
        send_item(mk(REQ_WRITE, 10'd0,   7'd26,  8'hFF, 1'b0));
        send_item(mk(REQ_WRITE, 10'd0,   7'd127, 8'hFF, 1'b0));
        send_item(mk(REQ_WRITE, 10'd0,   7'd25,  8'hFF, 1'b0));
        send_item(mk(REQ_READ,  10'd0,   7'd25,  8'h00, 1'b0));
        send_item(mk(REQ_READ,  10'd0,   7'd18,  8'h00, 1'b0));
        // channel 3 keeps a sample below its written max, then wraps to 0
        send_item(mk(REQ_CONV,  10'd1023, 7'd0,  8'h00, 1'b0));
        send_item(mk(REQ_CONV,  10'd1023, 7'd0,  8'h00, 1'b0));
        drain_results();
    endtask

    task automatic test_config_sweep();
        logic [7:0] vals [5];
        // all clear, all set, then random settings
        for (int pass = 0; pass < 3; pass++)
        begin
            for (int i = 0; i < 5; i++)
                vals[i] = (pass == 0) ? 8'h00 : (pass == 1) ? 8'hFF
                                                            : 8'($urandom_range(0, 255));
            program_regs(vals);
            run_random_events(300);
            drain_results();
        end
    endtask

    task automatic test_backpressure();
        tx_idle_en     = 1'b0;
        rx_idle_en     = 1'b0;
        rx_hold_cycles = HOLD_OFF_CYCLES;
        for (int i = 0; i < 80; i++)
            send_item(rand_scan_event());
        drain_results();
    endtask

    task automatic test_random_mix();
        logic [7:0] vals [5];
        for (int i = 0; i < 5; i++)
            vals[i] = 8'($urandom_range(0, 255));
        program_regs(vals);
        run_random_events(400);
        drain_results();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        reset_tracker_model();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_events();
        test_config_sweep();
        test_backpressure();
        test_random_mix();

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
